/* rtl/smau_pkg.sv */
// Shared types and constants of the segmented memory access unit.
package smau_pkg;

    localparam int DATA_W    = 32;
    localparam int PADDR_W   = 17;
    localparam int BADDR_W   = 17;
    localparam int SIZE_W    = 3;
    localparam int FUNC_W    = 2;
    localparam int BYTE_W    = 8;
    localparam int CFG_WORDS = 8;
    localparam int CFG_IDX_W = 3;

    localparam logic [FUNC_W-1:0] FUNC_RD   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WR   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_BYTE = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;

    localparam logic [DATA_W-1:0] SEG_RESTRICTED = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [DATA_W-1:0]  logical_address;
        logic [SIZE_W-1:0]  access_size;
        logic [DATA_W-1:0]  write_data;
        logic [BADDR_W-1:0] byte_address;
    } req_t;

    typedef struct packed {
        logic [DATA_W-1:0]  read_data;
        logic               fault;
        logic [DATA_W-1:0]  logical_address_reg;
        logic [PADDR_W-1:0] physical_address_reg;
        logic [DATA_W-1:0]  buffer_reg;
    } rsp_t;

    // Outcome of the segment lookup and bound checks
    typedef struct packed {
        logic               ok;
        logic [PADDR_W-1:0] phys;
    } xlate_t;

endpackage

/* rtl/smau_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module smau_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/smau_xlate.sv */
// Segment table and registered logical-to-physical translation with checks.
module smau_xlate #(
    parameter int MEM_BYTES     = 16384,
    parameter int SEGMENT_COUNT = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [smau_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [smau_pkg::DATA_W-1:0]     cfg_data,
    input  logic                            start,
    input  logic [smau_pkg::DATA_W-1:0]     laddr,
    input  logic [smau_pkg::SIZE_W-1:0]     size,
    output smau_pkg::xlate_t                res
);
    import smau_pkg::*;

    localparam logic [PADDR_W:0] MEM_LIM = (PADDR_W+1)'(MEM_BYTES);
    localparam logic [15:0]      SEG_LIM = 16'(SEGMENT_COUNT);

    logic [DATA_W-1:0] seg_reg [CFG_WORDS];
    xlate_t            res_reg;
    xlate_t            res_next;

    logic [15:0]        segno;
    logic [15:0]        offset;
    logic [DATA_W-1:0]  word;
    logic [PADDR_W-1:0] end_off;
    logic [PADDR_W-1:0] addr;
    logic [PADDR_W:0]   end_addr;
    logic               size_ok;
    logic               seg_ok;
    logic               lim_ok;
    logic               mem_ok;

    always_comb
    begin
        segno    = laddr[31:16];
        offset   = laddr[15:0];
        word     = seg_reg[segno[CFG_IDX_W-1:0]];
        size_ok  = (size >= SIZE_W'(1)) && (size <= SIZE_W'(4));
        seg_ok   = (segno < SEG_LIM) && (word != SEG_RESTRICTED);
        end_off  = {1'b0, offset} + PADDR_W'(size);
        lim_ok   = end_off <= {1'b0, word[15:0]};
        addr     = {1'b0, word[31:16]} + {1'b0, offset};
        end_addr = {1'b0, addr} + (PADDR_W+1)'(size);
        mem_ok   = end_addr <= MEM_LIM;
        res_next.ok   = size_ok && seg_ok && lim_ok && mem_ok;
        res_next.phys = addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CFG_WORDS; i++)
            begin
                seg_reg[i] <= SEG_RESTRICTED;
            end
        end
        else if (cfg_we)
        begin
            seg_reg[cfg_index] <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

/* rtl/segmented_memory_access_unit.sv */
// Top level of the segmented memory access unit: sequencer and byte-serial datapath.
//
// Use: one access word enters on req (req_valid/req_stall) and one response word
// leaves on rsp (rsp_valid/rsp_stall). func selects logical read, logical write
// or raw physical byte read; any other code answers with fault set.
// Segment words are written through cfg_we/cfg_index/cfg_data by the user only while
// the unit is idle; the unit itself does not enforce this. One access is in flight
// at a time. After acceptance the segment lookup and bound checks are registered,
// then the XLATE state takes their result; in the ACCESS state the byte-wide RAM
// moves one byte per cycle. A faulted access goes from XLATE straight to DONE, and
// DONE hands the response to the output register once it is free and returns to IDLE.
// The single RAM port pair (one byte each way) sets the pace of the ACCESS state.
// The response sits in an output register, so a new access is taken while a
// finished response is still stalled; the following response then waits in the
// final step until the output register frees up.
// Reset: all segment words read restricted, hold registers are zero, and the
// byte store is swept to zero, one byte a cycle, while req_stall is held high.
// Configuration writes are taken during the sweep.
module segmented_memory_access_unit #(
    parameter int MEM_BYTES     = 16384,
    parameter int SEGMENT_COUNT = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  smau_pkg::req_t                 req,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output smau_pkg::rsp_t                 rsp,
    input  logic                           cfg_we,
    input  logic [smau_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [smau_pkg::DATA_W-1:0]    cfg_data
);
    import smau_pkg::*;

    localparam int AW = $clog2(MEM_BYTES);
    localparam logic [AW-1:0]    LAST_ADDR = AW'(MEM_BYTES - 1);
    localparam logic [PADDR_W:0] MEM_LIM   = (PADDR_W+1)'(MEM_BYTES);

    // sequencer states
    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_XLATE  = 3'd2;
    localparam logic [2:0] ST_ACCESS = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic [AW-1:0]      clr_reg, clr_next;
    logic [SIZE_W-1:0]  cnt_reg, cnt_next;
    logic               pend_reg, pend_next;
    logic               rsp_valid_reg, rsp_valid_next;
    logic [DATA_W-1:0]  lhold_reg, lhold_next;
    logic [PADDR_W-1:0] phold_reg, phold_next;
    logic [DATA_W-1:0]  bhold_reg, bhold_next;

    // payload registers
    req_t               req_reg, req_next;
    logic               ok_reg, ok_next;
    logic [PADDR_W-1:0] phys_reg, phys_next;
    logic [SIZE_W-1:0]  size_reg, size_next;
    logic [DATA_W-1:0]  rd_sr_reg, rd_sr_next;   // read bytes shift in at the bottom
    logic [DATA_W-1:0]  ws_reg, ws_next;         // write bytes shift out at the bottom
    rsp_t               rsp_reg, rsp_next;

    xlate_t             xres;
    logic               xl_start;
    logic               accept;
    logic               slot_free;
    logic               byte_ok;
    logic               go_ok;
    logic [PADDR_W-1:0] go_phys;
    logic [SIZE_W-1:0]  go_size;
    logic [PADDR_W-1:0] rd_addr;
    logic [SIZE_W-1:0]  wr_off;
    logic [PADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0]  rdv;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [BYTE_W-1:0]  ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [BYTE_W-1:0]  ram_rdata;

    smau_xlate #(
        .MEM_BYTES     (MEM_BYTES),
        .SEGMENT_COUNT (SEGMENT_COUNT)
    ) u_xlate (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .start     (xl_start),
        .laddr     (req.logical_address),
        .size      (req.access_size),
        .res       (xres)
    );

    smau_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MEM_BYTES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;
    assign slot_free = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // raw byte read range check
    assign byte_ok = {1'b0, req_reg.byte_address} < MEM_LIM;

    // reads walk upward from the base; writes walk downward, low byte first
    assign rd_addr = phys_reg + PADDR_W'(cnt_reg);
    assign wr_off  = size_reg - SIZE_W'(1) - cnt_reg;
    assign wr_addr = phys_reg + PADDR_W'(wr_off);

    always_comb
    begin
        case (req_reg.func)
            FUNC_RD, FUNC_WR:
            begin
                go_ok   = xres.ok;
                go_phys = xres.phys;
                go_size = req_reg.access_size;
            end
            FUNC_BYTE:
            begin
                go_ok   = byte_ok;
                go_phys = req_reg.byte_address;
                go_size = SIZE_W'(1);
            end
            default:
            begin
                go_ok   = 1'b0;
                go_phys = '0;
                go_size = '0;
            end
        endcase
    end

    always_comb
    begin
        case (req_reg.func)
            FUNC_RD:   rdv = rd_sr_reg;
            FUNC_BYTE: rdv = {{(DATA_W-BYTE_W){rd_sr_reg[BYTE_W-1]}}, rd_sr_reg[BYTE_W-1:0]};
            default:   rdv = '0;
        endcase
        if (!ok_reg)
        begin
            rdv = '0;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        cnt_next       = cnt_reg;
        pend_next      = pend_reg;
        rsp_valid_next = rsp_valid_reg;
        lhold_next     = lhold_reg;
        phold_next     = phold_reg;
        bhold_next     = bhold_reg;
        req_next       = req_reg;
        ok_next        = ok_reg;
        phys_next      = phys_reg;
        size_next      = size_reg;
        rd_sr_next     = rd_sr_reg;
        ws_next        = ws_reg;
        rsp_next       = rsp_reg;
        xl_start       = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = clr_reg;
        ram_wdata      = '0;
        ram_raddr      = rd_addr[AW-1:0];

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we   = 1'b1;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    req_next   = req;
                    xl_start   = 1'b1;
                    state_next = ST_XLATE;
                end
            end
            ST_XLATE:
            begin
                ok_next    = go_ok;
                phys_next  = go_phys;
                size_next  = go_size;
                cnt_next   = '0;
                pend_next  = 1'b0;
                rd_sr_next = '0;
                ws_next    = req_reg.write_data;
                state_next = go_ok ? ST_ACCESS : ST_DONE;
            end
            ST_ACCESS:
            begin
                if (req_reg.func == FUNC_WR)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = wr_addr[AW-1:0];
                    ram_wdata = ws_reg[BYTE_W-1:0];
                    ws_next   = ws_reg >> BYTE_W;
                    cnt_next  = cnt_reg + SIZE_W'(1);
                    if (cnt_reg == size_reg - SIZE_W'(1))
                    begin
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    // RAM read data is registered and arrives in the cycle after its address
                    pend_next = (cnt_reg != size_reg);
                    if (cnt_reg != size_reg)
                    begin
                        cnt_next = cnt_reg + SIZE_W'(1);
                    end
                    if (pend_reg)
                    begin
                        rd_sr_next = {rd_sr_reg[DATA_W-BYTE_W-1:0], ram_rdata};
                    end
                    if ((cnt_reg == size_reg) && pend_reg)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    if ((req_reg.func == FUNC_RD) || (req_reg.func == FUNC_WR))
                    begin
                        lhold_next = req_reg.logical_address;
                        if (ok_reg)
                        begin
                            phold_next = phys_reg;
                            bhold_next = (req_reg.func == FUNC_WR) ? req_reg.write_data
                                                                    : rd_sr_reg;
                        end
                    end
                    rsp_next.read_data            = rdv;
                    rsp_next.fault                = !ok_reg;
                    rsp_next.logical_address_reg  = lhold_next;
                    rsp_next.physical_address_reg = phold_next;
                    rsp_next.buffer_reg           = bhold_next;
                    rsp_valid_next                = 1'b1;
                    state_next                    = ST_IDLE;
                end
            end
            default:
            begin
                clr_next   = '0;
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
            lhold_reg     <= '0;
            phold_reg     <= '0;
            bhold_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
            lhold_reg     <= lhold_next;
            phold_reg     <= phold_next;
            bhold_reg     <= bhold_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        ok_reg    <= ok_next;
        phys_reg  <= phys_next;
        size_reg  <= size_next;
        rd_sr_reg <= rd_sr_next;
        ws_reg    <= ws_next;
        rsp_reg   <= rsp_next;
    end

endmodule

/* rtl/smau_chk.sv */
// Port-level checker for the segmented memory access unit, bound to the top level.
module smau_chk (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_stall,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input smau_pkg::rsp_t rsp
);
    import smau_pkg::*;

    // a stalled response word holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // one access in flight: an accept closes the input side
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("input open right after an accept");

    // a faulted access returns zero data
    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.fault |-> rsp.read_data == '0)
        else $error("fault with nonzero read data");

    // a fresh response word comes with the input side open again
    a_rsp_frees: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> !req_stall)
        else $error("new response while input still closed");

endmodule

bind segmented_memory_access_unit smau_chk u_smau_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
